/* hdl/mspm_pkg.sv */
// ============================================================================
// mspm_pkg
// Shared types, codes and default sizes for the masked sparse matrix product.
// ============================================================================
package mspm_pkg;

    localparam int ROWS_DEF        = 256;
    localparam int COLS_DEF        = 256;
    localparam int NNZ_DEF         = 4096;
    localparam int MAX_ROW_NNZ_DEF = 32;

    // item opcodes
    localparam logic [1:0] OP_LOAD_B  = 2'd0;
    localparam logic [1:0] OP_LOAD_A  = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    localparam logic signed [63:0] ACC_MAX = 64'sh7fffffffffffffff;
    localparam logic signed [63:0] ACC_MIN = 64'sh8000000000000000;
    localparam logic signed [63:0] Q32_MAX = 64'sh000000007fffffff;
    localparam logic signed [63:0] Q32_MIN = 64'shffffffff80000000;

    typedef struct packed {
        logic               valid;
        logic [7:0]         row;
        logic [7:0]         col;
        logic signed [31:0] value;
    } load_cmd_t;

    typedef struct packed {
        logic mul;
        logic clr;
    } mac_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_WRITE
    } store_state_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOAD,
        S_BS0,
        S_BS1,
        S_MAP_RD,
        S_MAP_WR,
        S_A_RD,
        S_A_DAT,
        S_K0,
        S_K1,
        S_K_RD,
        S_K_MAP,
        S_K_MAC,
        S_DRAIN,
        S_O_RD,
        S_O_LOAD,
        S_O_WAIT
    } seq_state_t;

endpackage

/* hdl/mspm_item_if.sv */
// ============================================================================
// mspm_item_if
// Input channel: load and compute items.
// ============================================================================
interface mspm_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [7:0]         row;
    logic [7:0]         col;
    logic signed [31:0] value;

    modport source (output valid, op, row, col, value, input ready);
    modport sink   (input valid, op, row, col, value, output ready);
endinterface

/* hdl/mspm_result_if.sv */
// ============================================================================
// mspm_result_if
// Output channel: one result entry per transfer.
// ============================================================================
interface mspm_result_if;
    logic               valid;
    logic               ready;
    logic [7:0]         out_col;
    logic signed [31:0] product_value;
    logic               saturated;
    logic               last;

    modport source (output valid, out_col, product_value, saturated, last, input ready);
    modport sink   (input valid, out_col, product_value, saturated, last, output ready);
endinterface

/* hdl/mspm_csr_store.sv */
// ============================================================================
// mspm_csr_store
// One compressed-row matrix: entry memory, row start memory, load sequencer.
// ============================================================================
module mspm_csr_store #(
    parameter int ROWS    = mspm_pkg::ROWS_DEF,
    parameter int NNZ     = mspm_pkg::NNZ_DEF,
    parameter int ROW_CAP = mspm_pkg::MAX_ROW_NNZ_DEF,
    localparam int EIW    = (NNZ > 1) ? $clog2(NNZ) : 1,
    localparam int ECW    = $clog2(NNZ + 1),
    localparam int RIW    = (ROWS > 1) ? $clog2(ROWS) : 1,
    localparam int RQW    = $clog2(ROWS + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mspm_pkg::load_cmd_t  ld,
    output logic                 busy,
    input  logic [EIW-1:0]       ent_addr,
    output logic [7:0]           ent_col,
    output logic signed [31:0]   ent_value,
    input  logic [RQW-1:0]       st_row,
    output logic [ECW-1:0]       st_value
);
    import mspm_pkg::*;

    logic [39:0]    ent_mem [NNZ];
    logic [ECW-1:0] start_mem [ROWS];

    store_state_t   state_reg, state_next;
    logic [ECW-1:0] cnt_reg, cnt_next;
    logic [RIW-1:0] last_reg, last_next;
    logic [ECW-1:0] lstart_reg, lstart_next;
    logic [RQW-1:0] fill_reg, fill_next;
    logic [RIW-1:0] row_reg, row_next;
    logic [7:0]         col_reg, col_next;
    logic signed [31:0] value_reg, value_next;

    logic [39:0]    ent_rd_reg;
    logic [ECW-1:0] st_rd_reg;
    logic           st_sel_reg;

    logic           empty, full, row_ok, same, behind, capped, take;
    logic [RQW-1:0] r_q, last_q;
    logic [ECW-1:0] row_cnt;

    always_comb
    begin
        r_q     = RQW'(ld.row);
        last_q  = RQW'(last_reg);
        empty   = (cnt_reg == '0);
        full    = (32'(cnt_reg) >= NNZ);
        row_ok  = (32'(ld.row) < ROWS);
        same    = !empty && (r_q == last_q);
        behind  = !empty && (r_q < last_q);
        row_cnt = same ? (cnt_reg - lstart_reg) : '0;
        capped  = (32'(row_cnt) >= ROW_CAP);
        take    = ld.valid && row_ok && !full && !behind && !capped;

        state_next  = state_reg;
        cnt_next    = cnt_reg;
        last_next   = last_reg;
        lstart_next = lstart_reg;
        fill_next   = fill_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        value_next  = value_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    row_next   = RIW'(ld.row);
                    col_next   = ld.col;
                    value_next = ld.value;
                    fill_next  = empty ? '0 : RQW'(last_q + 1'b1);
                    state_next = same ? ST_WRITE : ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                fill_next = RQW'(fill_reg + 1'b1);
                if (fill_reg == RQW'(row_reg))
                begin
                    lstart_next = cnt_reg;
                    state_next  = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cnt_next   = ECW'(cnt_reg + 1'b1);
                last_next  = row_reg;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            last_reg   <= '0;
            lstart_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            last_reg   <= last_next;
            lstart_reg <= lstart_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg   <= row_next;
        col_reg   <= col_next;
        value_reg <= value_next;
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SWEEP)
        begin
            start_mem[fill_reg[RIW-1:0]] <= cnt_reg;
        end
        if (state_reg == ST_WRITE)
        begin
            ent_mem[cnt_reg[EIW-1:0]] <= {col_reg, value_reg};
        end
        ent_rd_reg <= ent_mem[ent_addr];
        st_rd_reg  <= start_mem[st_row[RIW-1:0]];
        st_sel_reg <= (cnt_reg == '0) || (st_row > RQW'(last_reg));
    end

    // rows past the last loaded one start at the fill count
    assign st_value  = st_sel_reg ? cnt_reg : st_rd_reg;
    assign ent_col   = ent_rd_reg[39:32];
    assign ent_value = ent_rd_reg[31:0];
    assign busy      = (state_reg != ST_IDLE);

endmodule

/* hdl/mspm_mac.sv */
// ============================================================================
// mspm_mac
// Shared multiply, round and saturating accumulate unit with accumulator bank.
// ============================================================================
module mspm_mac #(
    parameter int MAX_ROW_NNZ = mspm_pkg::MAX_ROW_NNZ_DEF,
    localparam int PW         = (MAX_ROW_NNZ > 1) ? $clog2(MAX_ROW_NNZ) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mspm_pkg::mac_ctl_t  ctl,
    input  logic [PW-1:0]       pos,
    input  logic signed [31:0]  a,
    input  logic signed [31:0]  b,
    input  logic [PW-1:0]       rd_idx,
    output logic signed [63:0]  rd_data,
    output logic                busy
);
    import mspm_pkg::*;

    logic signed [63:0] acc_reg [MAX_ROW_NNZ];

    logic               v1_reg, v2_reg;
    logic [PW-1:0]      pos1_reg, pos2_reg;
    logic signed [63:0] prod_reg, rnd_reg;
    logic signed [63:0] rnd_next, sum_next;
    logic [PW-1:0]      acc_addr;
    logic signed [64:0] sum_wide;

    always_comb
    begin
        // floor((p + 2^15) / 2^16)
        rnd_next = (prod_reg + 64'sd32768) >>> 16;
        acc_addr = v2_reg ? pos2_reg : rd_idx;
        rd_data  = acc_reg[acc_addr];
        sum_wide = {rd_data[63], rd_data} + {rnd_reg[63], rnd_reg};
        if (sum_wide[64] != sum_wide[63])
        begin
            sum_next = sum_wide[64] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            sum_next = sum_wide[63:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctl.mul;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        pos1_reg <= pos;
        rnd_reg  <= rnd_next;
        pos2_reg <= pos1_reg;
        if (ctl.clr)
        begin
            acc_reg[pos] <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg[pos2_reg] <= sum_next;
        end
    end

    assign busy = v1_reg || v2_reg;

endmodule

/* hdl/masked_sparse_matrix_product.sv */
// ============================================================================
// masked_sparse_matrix_product
// Row of C = A*B restricted to the pattern of B's row, Q16.16 values.
// ============================================================================
// Load: skipped rows get their start filled before the entry is written.
// Compute: map set-up, walk over A entries and their B rows, then result reads, in
//   turn and slowed by output stalls; set by the single read port of each entry
//   memory and the one shared multiply-accumulate unit.
// One item at a time; ready is low until it is done (compute: last result sent).
// Reset (async, active low) empties both matrices and the column map.
module masked_sparse_matrix_product #(
    parameter int ROWS        = mspm_pkg::ROWS_DEF,
    parameter int COLS        = mspm_pkg::COLS_DEF,
    parameter int NNZ         = mspm_pkg::NNZ_DEF,
    parameter int MAX_ROW_NNZ = mspm_pkg::MAX_ROW_NNZ_DEF
) (
    input logic            clk,
    input logic            rst_n,
    mspm_item_if.sink      item,
    mspm_result_if.source  result
);
    import mspm_pkg::*;

    localparam int EIW = (NNZ > 1) ? $clog2(NNZ) : 1;
    localparam int ECW = $clog2(NNZ + 1);
    localparam int RQW = $clog2(ROWS + 1);
    localparam int CIW = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int PW  = (MAX_ROW_NNZ > 1) ? $clog2(MAX_ROW_NNZ) : 1;
    localparam int PCW = $clog2(MAX_ROW_NNZ + 1);

    // ---------------- storage units ----------------
    load_cmd_t          b_ld, a_ld;
    logic               b_busy, a_busy;
    logic [EIW-1:0]     b_ent_addr, a_ent_addr;
    logic [7:0]         b_ent_col, a_ent_col;
    logic signed [31:0] b_ent_value, a_ent_value;
    logic [RQW-1:0]     b_st_row, a_st_row;
    logic [ECW-1:0]     b_st_value, a_st_value;

    // B rows are capped at MAX_ROW_NNZ entries, A rows only by the store size
    mspm_csr_store #(.ROWS(ROWS), .NNZ(NNZ), .ROW_CAP(MAX_ROW_NNZ)) u_b_store (
        .clk(clk), .rst_n(rst_n), .ld(b_ld), .busy(b_busy),
        .ent_addr(b_ent_addr), .ent_col(b_ent_col), .ent_value(b_ent_value),
        .st_row(b_st_row), .st_value(b_st_value)
    );

    mspm_csr_store #(.ROWS(ROWS), .NNZ(NNZ), .ROW_CAP(NNZ)) u_a_store (
        .clk(clk), .rst_n(rst_n), .ld(a_ld), .busy(a_busy),
        .ent_addr(a_ent_addr), .ent_col(a_ent_col), .ent_value(a_ent_value),
        .st_row(a_st_row), .st_value(a_st_value)
    );

    // ---------------- shared MAC ----------------
    mac_ctl_t           mac_ctl;
    logic [PW-1:0]      mac_pos;
    logic signed [63:0] mac_rd_data;
    logic               mac_busy;

    // ---------------- sequencer state ----------------
    seq_state_t         state_reg, state_next;
    logic [7:0]         row_reg, row_next;
    logic [ECW-1:0]     bs_reg, bs_next;
    logic [ECW-1:0]     ja_reg, ja_next;
    logic [ECW-1:0]     ae_reg, ae_next;
    logic [ECW-1:0]     k_reg, k_next;
    logic [ECW-1:0]     ke_reg, ke_next;
    logic [PCW-1:0]     n_reg, n_next;
    logic [PCW-1:0]     j_reg, j_next;
    logic [7:0]         br_reg, br_next;
    logic signed [31:0] av_reg, av_next;
    logic signed [31:0] bv_reg, bv_next;
    logic               hit_reg, hit_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_col_reg, out_col_next;
    logic signed [31:0] out_value_reg, out_value_next;
    logic               out_sat_reg, out_sat_next;
    logic               out_last_reg, out_last_next;

    // column -> position map: valid bits in flops, positions in a memory
    logic [COLS-1:0]    map_valid_reg;
    logic [PW-1:0]      map_pos_mem [COLS];
    logic [PW-1:0]      map_pos_rd_reg;
    logic [CIW-1:0]     map_col;
    logic               map_set, map_clr;

    logic               in_fire;
    logic [ECW-1:0]     b_diff;
    logic [ECW-1:0]     j_ext;

    assign map_col = CIW'(b_ent_col);
    assign j_ext   = ECW'(j_reg);

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        bs_next        = bs_reg;
        ja_next        = ja_reg;
        ae_next        = ae_reg;
        k_next         = k_reg;
        ke_next        = ke_reg;
        n_next         = n_reg;
        j_next         = j_reg;
        br_next        = br_reg;
        av_next        = av_reg;
        bv_next        = bv_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        out_col_next   = out_col_reg;
        out_value_next = out_value_reg;
        out_sat_next   = out_sat_reg;
        out_last_next  = out_last_reg;

        item.ready = 1'b0;
        in_fire    = 1'b0;
        b_ld       = '{valid: 1'b0, row: item.row, col: item.col, value: item.value};
        a_ld       = '{valid: 1'b0, row: item.row, col: item.col, value: item.value};
        b_ent_addr = EIW'(bs_reg + j_ext);
        a_ent_addr = EIW'(ja_reg);
        b_st_row   = RQW'(item.row);
        a_st_row   = RQW'(item.row);
        mac_ctl    = '{mul: 1'b0, clr: 1'b0};
        mac_pos    = map_pos_rd_reg;
        map_set    = 1'b0;
        map_clr    = 1'b0;
        b_diff     = b_st_value - bs_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                item.ready = 1'b1;
                in_fire    = item.valid;
                if (in_fire)
                begin
                    priority case (item.op)
                        OP_LOAD_B:
                        begin
                            // columns outside the matrix are dropped here
                            b_ld.valid = (32'(item.col) < COLS);
                            state_next = S_LOAD;
                        end
                        OP_LOAD_A:
                        begin
                            a_ld.valid = 1'b1;
                            state_next = S_LOAD;
                        end
                        OP_COMPUTE:
                        begin
                            // start(row) lookups go out now
                            row_next = item.row;
                            if (32'(item.row) < ROWS)
                            begin
                                state_next = S_BS0;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_LOAD:
            begin
                if (!b_busy && !a_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_BS0:
            begin
                bs_next  = b_st_value;
                ja_next  = a_st_value;
                b_st_row = RQW'(9'(row_reg) + 9'd1);
                a_st_row = RQW'(9'(row_reg) + 9'd1);
                state_next = S_BS1;
            end
            S_BS1:
            begin
                ae_next = a_st_value;
                j_next  = '0;
                if (b_st_value > bs_reg)
                begin
                    n_next = (32'(b_diff) > MAX_ROW_NNZ) ? PCW'(MAX_ROW_NNZ)
                                                           : PCW'(b_diff);
                    state_next = S_MAP_RD;
                end
                else
                begin
                    // empty B row: no results
                    state_next = S_IDLE;
                end
            end
            S_MAP_RD:
            begin
                state_next = S_MAP_WR;
            end
            S_MAP_WR:
            begin
                // later duplicates of a column overwrite the position
                map_set     = 1'b1;
                mac_ctl.clr = 1'b1;
                mac_pos     = PW'(j_reg);
                if (PCW'(j_reg + 1'b1) == n_reg)
                begin
                    state_next = S_A_RD;
                end
                else
                begin
                    j_next     = PCW'(j_reg + 1'b1);
                    state_next = S_MAP_RD;
                end
            end
            S_A_RD:
            begin
                if (ja_reg == ae_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    state_next = S_A_DAT;
                end
            end
            S_A_DAT:
            begin
                av_next  = a_ent_value;
                br_next  = a_ent_col;
                b_st_row = RQW'(a_ent_col);
                if (32'(a_ent_col) >= ROWS)
                begin
                    // no such B row: counts as empty
                    ja_next    = ECW'(ja_reg + 1'b1);
                    state_next = S_A_RD;
                end
                else
                begin
                    state_next = S_K0;
                end
            end
            S_K0:
            begin
                k_next     = b_st_value;
                b_st_row   = RQW'(9'(br_reg) + 9'd1);
                state_next = S_K1;
            end
            S_K1:
            begin
                ke_next    = b_st_value;
                state_next = S_K_RD;
            end
            S_K_RD:
            begin
                b_ent_addr = EIW'(k_reg);
                if (k_reg == ke_reg)
                begin
                    ja_next    = ECW'(ja_reg + 1'b1);
                    state_next = S_A_RD;
                end
                else
                begin
                    state_next = S_K_MAP;
                end
            end
            S_K_MAP:
            begin
                b_ent_addr = EIW'(k_reg);
                hit_next   = map_valid_reg[map_col];
                bv_next    = b_ent_value;
                state_next = S_K_MAC;
            end
            S_K_MAC:
            begin
                mac_ctl.mul = hit_reg;
                k_next      = ECW'(k_reg + 1'b1);
                state_next  = S_K_RD;
            end
            S_DRAIN:
            begin
                j_next = '0;
                if (!mac_busy)
                begin
                    state_next = S_O_RD;
                end
            end
            S_O_RD:
            begin
                state_next = S_O_LOAD;
            end
            S_O_LOAD:
            begin
                map_clr       = 1'b1;
                out_col_next  = b_ent_col;
                out_last_next = (PCW'(j_reg + 1'b1) == n_reg);
                if (mac_rd_data > Q32_MAX)
                begin
                    out_value_next = 32'sh7fffffff;
                    out_sat_next   = 1'b1;
                end
                else if (mac_rd_data < Q32_MIN)
                begin
                    out_value_next = 32'sh80000000;
                    out_sat_next   = 1'b1;
                end
                else
                begin
                    out_value_next = mac_rd_data[31:0];
                    out_sat_next   = 1'b0;
                end
                out_valid_next = 1'b1;
                state_next     = S_O_WAIT;
            end
            S_O_WAIT:
            begin
                if (result.ready)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        j_next     = PCW'(j_reg + 1'b1);
                        state_next = S_O_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    mspm_mac #(.MAX_ROW_NNZ(MAX_ROW_NNZ)) u_mac (
        .clk(clk), .rst_n(rst_n), .ctl(mac_ctl), .pos(mac_pos),
        .a(av_reg), .b(bv_reg), .rd_idx(PW'(j_reg)),
        .rd_data(mac_rd_data), .busy(mac_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            map_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (map_set)
            begin
                map_valid_reg[map_col] <= 1'b1;
            end
            else if (map_clr)
            begin
                map_valid_reg[map_col] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg       <= row_next;
        bs_reg        <= bs_next;
        ja_reg        <= ja_next;
        ae_reg        <= ae_next;
        k_reg         <= k_next;
        ke_reg        <= ke_next;
        n_reg         <= n_next;
        j_reg         <= j_next;
        br_reg        <= br_next;
        av_reg        <= av_next;
        bv_reg        <= bv_next;
        hit_reg       <= hit_next;
        out_col_reg   <= out_col_next;
        out_value_reg <= out_value_next;
        out_sat_reg   <= out_sat_next;
        out_last_reg  <= out_last_next;
    end

    // map position memory
    always_ff @(posedge clk)
    begin
        if (map_set)
        begin
            map_pos_mem[map_col] <= PW'(j_reg);
        end
        map_pos_rd_reg <= map_pos_mem[map_col];
    end

    assign result.valid         = out_valid_reg;
    assign result.out_col       = out_col_reg;
    assign result.product_value = out_value_reg;
    assign result.saturated     = out_sat_reg;
    assign result.last          = out_last_reg;

endmodule

/* hdl/mspm_checker.sv */
// ============================================================================
// mspm_checker
// Port-level checks of the item and result channels.
// ============================================================================
module mspm_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_last
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // no new item while a result row is being delivered
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("item ready while result pending");

    // results never appear the cycle after an item transfer
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result too soon after item");

    // the row ends with its last entry
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last |=> !out_valid)
        else $error("result after last entry");

endmodule

bind masked_sparse_matrix_product mspm_checker u_mspm_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(item.valid),
    .in_ready(item.ready),
    .out_valid(result.valid),
    .out_ready(result.ready),
    .out_last(result.last)
);

/* verif/tb_top.sv */
// ============================================================================
// tb_top
// Self-checking testbench for masked_sparse_matrix_product. It starts with a
// directed table, then random row-major load/compute episodes and noise.
// A few appended loads and computes close the run. Every result transfer is
// checked against an in-bench masked-product predictor or the table's entry.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;
    import mspm_pkg::*;

    localparam int ROWS        = ROWS_DEF;
    localparam int COLS        = COLS_DEF;
    localparam int NNZ         = NNZ_DEF;
    localparam int MAX_ROW_NNZ = MAX_ROW_NNZ_DEF;

    // op 3 has no function in the block
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // matrix index into the predictor stores, follows the load opcodes
    localparam int MAT_B = 0;
    localparam int MAT_A = 1;
    // table marker: the predictor supplies the expected transfers
    localparam int FROM_PREDICTOR = -1;

    localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] Q_MIN = 32'sh80000000;
    localparam logic signed [31:0] Q_ONE = 32'sh00010000;

    typedef struct {
        logic [7:0]         out_col;
        logic signed [31:0] product_value;
        logic               saturated;
        logic               last;
    } product_entry_t;

    typedef struct {
        logic [1:0]         op;
        logic [7:0]         row;
        logic [7:0]         col;
        logic signed [31:0] value;
        int                 exp_count;    // FROM_PREDICTOR, 0 or 1
        logic [7:0]         exp_col;
        logic signed [31:0] exp_value;
        logic               exp_sat;
        logic               exp_last;
    } directed_row_t;

    logic clk;
    logic rst_n;

    mspm_item_if   item_ch ();
    mspm_result_if result_ch ();

    masked_sparse_matrix_product u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch.sink),
        .result (result_ch.source)
    );

    // ------------------------------------------------------------------------
    // Predictor state: compressed-row copies of B and A
    // ------------------------------------------------------------------------
    logic [7:0]         entry_col  [2][NNZ];
    logic signed [31:0] entry_val  [2][NNZ];
    int unsigned        row_start  [2][ROWS+1];
    int unsigned        last_row   [2];

    product_entry_t product_q[$];

    int error_count;
    int sent_count;
    int src_idle_pct;
    int snk_stall_pct;
    int hold_cycles;
    logic [7:0] col_pool[12];

    // Append one entry to matrix m; drops follow the block's load rules: bad row,
    // full store, backwards row, and (B only) a bad column or a row at its limit.
    function automatic void store_entry(int m, int unsigned r, int unsigned c,
                                        logic signed [31:0] v);
        int unsigned n;
        n = row_start[m][ROWS];
        if (r >= ROWS || n >= NNZ)
            return;
        if (m == MAT_B && c >= COLS)
            return;
        if (n > 0 && r < last_row[m])
            return;
        if (m == MAT_B && n - row_start[m][r] >= MAX_ROW_NNZ)
            return;
        entry_col[m][n] = c[7:0];
        entry_val[m][n] = v;
        for (int unsigned k = r + 1; k <= ROWS; k++)
            row_start[m][k] = n + 1;
        last_row[m] = r;
    endfunction

    // Q16.16 product, round half up: floor((a*b + 2^15) / 2^16)
    function automatic longint q16_product(logic signed [31:0] a, logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b) + 64'sd32768;
        return p >>> 16;
    endfunction

    function automatic longint add_clip64(longint a, longint b);
        longint s;
        s = a + b;
        if (a > 0 && b > 0 && s < 0)
            return ACC_MAX;
        if (a < 0 && b < 0 && s >= 0)
            return ACC_MIN;
        return s;
    endfunction

    // Queue the transfers that a compute of row r yields.
    function automatic void predict_masked_row(int unsigned r);
        int             slot_of[COLS];
        longint         acc[MAX_ROW_NNZ];
        int unsigned    bs, be, n, br;
        product_entry_t e;
        if (r >= ROWS)
            return;
        bs = row_start[MAT_B][r];
        be = row_start[MAT_B][r+1];
        if (be <= bs)
            return;
        n = be - bs;
        if (n > MAX_ROW_NNZ)
            n = MAX_ROW_NNZ;
        foreach (slot_of[c])
            slot_of[c] = -1;
        // a repeated column maps to its later slot
        for (int unsigned j = 0; j < n; j++)
        begin
            acc[j] = 0;
            slot_of[entry_col[MAT_B][bs+j]] = j;
        end
        for (int unsigned j = row_start[MAT_A][r]; j < row_start[MAT_A][r+1]; j++)
        begin
            br = entry_col[MAT_A][j];
            if (br >= ROWS)
                continue;
            for (int unsigned k = row_start[MAT_B][br]; k < row_start[MAT_B][br+1]; k++)
            begin
                if (slot_of[entry_col[MAT_B][k]] >= 0)
                    acc[slot_of[entry_col[MAT_B][k]]] =
                        add_clip64(acc[slot_of[entry_col[MAT_B][k]]],
                                   q16_product(entry_val[MAT_A][j], entry_val[MAT_B][k]));
            end
        end
        for (int unsigned j = 0; j < n; j++)
        begin
            e.out_col   = entry_col[MAT_B][bs+j];
            e.saturated = 1'b1;
            if (acc[j] > Q32_MAX)
                e.product_value = Q_MAX;
            else if (acc[j] < Q32_MIN)
                e.product_value = Q_MIN;
            else
            begin
                e.product_value = acc[j][31:0];
                e.saturated     = 1'b0;
            end
            e.last = (j + 1 == n);
            product_q.push_back(e);
        end
    endfunction

    // Apply an accepted item to the predictor; computes queue their results if queue_results is set.
    function automatic void predict_item(logic [1:0] op, logic [7:0] r, logic [7:0] c,
                                         logic signed [31:0] v, bit queue_results);
        case (op)
            OP_LOAD_B:  store_entry(MAT_B, r, c, v);
            OP_LOAD_A:  store_entry(MAT_A, r, c, v);
            OP_COMPUTE: if (queue_results) predict_masked_row(r);
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Clock, reset, time limit
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("masked_sparse_matrix_product regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Input side. valid is lowered only while idling, so a back-to-back
    // transfer never sees two assignments in one step.
    // ------------------------------------------------------------------------
    task automatic send_item(logic [1:0] op, logic [7:0] r, logic [7:0] c,
                             logic signed [31:0] v, int exp_count, product_entry_t exp_e);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.op    <= op;
        item_ch.row   <= r;
        item_ch.col   <= c;
        item_ch.value <= v;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        // transfer taken at this edge
        predict_item(op, r, c, v, exp_count == FROM_PREDICTOR);
        if (exp_count == 1)
            product_q.push_back(exp_e);
        sent_count++;
        // idle mix rotates: none, sender idle, receiver stall, both
        case ((sent_count / 90) % 4)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 56; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 56; end
            default: begin src_idle_pct = 31; snk_stall_pct = 31; end
        endcase
    endtask

    task automatic send_checked(logic [1:0] op, logic [7:0] r, logic [7:0] c,
                                logic signed [31:0] v);
        product_entry_t none;
        none = '{default: '0};
        send_item(op, r, c, v, FROM_PREDICTOR, none);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2, 3, 4: return $urandom;
            default: return int'($urandom_range(0, 8 << 16)) - (4 << 16);
        endcase
    endfunction

    // One well-formed episode: a fresh B row, an A row mostly over B rows up to
    // its own, then its compute, now and then a recompute of a row up to it.
    task automatic run_episode();
        int unsigned r, kb, ka;
        r  = ((last_row[MAT_B] > last_row[MAT_A]) ? last_row[MAT_B] : last_row[MAT_A])
             + $urandom_range(1, 2);
        kb = ($urandom_range(0, 15) == 0) ? MAX_ROW_NNZ + 1 : $urandom_range(1, 6);
        ka = $urandom_range(0, 5);
        for (int i = 0; i < kb; i++)
            send_checked(OP_LOAD_B, r, col_pool[$urandom_range(0, 11)], pick_value());
        for (int i = 0; i < ka; i++)
            send_checked(OP_LOAD_A, r,
                         ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, r),
                         pick_value());
        send_checked(OP_COMPUTE, r, $urandom, $urandom);
        if ($urandom_range(0, 2) == 0)
            send_checked(OP_COMPUTE, $urandom_range(0, r), $urandom, $urandom);
    endtask

    // Noise: any op; loads land at or behind the current row so they are
    // either appended to it or dropped as out of order.
    task automatic run_noise();
        logic [1:0] op;
        for (int i = $urandom_range(1, 3); i > 0; i--)
        begin
            op = $urandom_range(0, 3);
            if (op == OP_LOAD_B || op == OP_LOAD_A)
                send_checked(op, $urandom_range(0, last_row[op]), $urandom, $urandom);
            else
                send_checked(op, $urandom, $urandom, $urandom);
        end
    endtask

    directed_row_t directed[] = '{
        // compute right after reset: nothing stored
        '{OP_COMPUTE, 8'd0,   8'd0,   32'sd0, 0, 8'd0, 32'sd0, 1'b0, 1'b0},
        // unused op
        '{OP_UNUSED,  8'd255, 8'd255, Q_MIN,  0, 8'd0, 32'sd0, 1'b0, 1'b0},
        '{OP_LOAD_B,  8'd1,   8'd5,   Q_MAX,  FROM_PREDICTOR, 8'd0, 32'sd0, 1'b0, 1'b0},
        '{OP_LOAD_B,  8'd1,   8'd255, Q_MIN,  FROM_PREDICTOR, 8'd0, 32'sd0, 1'b0, 1'b0},
        // repeated column in B row 1
        '{OP_LOAD_B,  8'd1,   8'd5,   Q_ONE,  FROM_PREDICTOR, 8'd0, 32'sd0, 1'b0, 1'b0},
        // backwards row, dropped
        '{OP_LOAD_B,  8'd0,   8'd1,   Q_ONE,  FROM_PREDICTOR, 8'd0, 32'sd0, 1'b0, 1'b0},
        '{OP_LOAD_B,  8'd2,   8'd0,   Q_ONE,  FROM_PREDICTOR, 8'd0, 32'sd0, 1'b0, 1'b0},
        '{OP_LOAD_B,  8'd3,   8'd7,   Q_MAX,  FROM_PREDICTOR, 8'd0, 32'sd0, 1'b0, 1'b0},
        '{OP_LOAD_A,  8'd1,   8'd1,   Q_MAX,  FROM_PREDICTOR, 8'd0, 32'sd0, 1'b0, 1'b0},
        '{OP_LOAD_A,  8'd1,   8'd2,   Q_ONE,  FROM_PREDICTOR, 8'd0, 32'sd0, 1'b0, 1'b0},
        // A column naming a B row never loaded
        '{OP_LOAD_A,  8'd1,   8'd200, Q_MAX,  FROM_PREDICTOR, 8'd0, 32'sd0, 1'b0, 1'b0},
        '{OP_LOAD_A,  8'd0,   8'd0,   Q_ONE,  FROM_PREDICTOR, 8'd0, 32'sd0, 1'b0, 1'b0},
        '{OP_LOAD_A,  8'd3,   8'd3,   Q_MAX,  FROM_PREDICTOR, 8'd0, 32'sd0, 1'b0, 1'b0},
        '{OP_COMPUTE, 8'd1,   8'd0,   32'sd0, FROM_PREDICTOR, 8'd0, 32'sd0, 1'b0, 1'b0},
        // max * max clips high
        '{OP_COMPUTE, 8'd3,   8'd0,   32'sd0, 1, 8'd7, Q_MAX,  1'b1, 1'b1},
        // B row 2 present, A row 2 empty
        '{OP_COMPUTE, 8'd2,   8'd0,   32'sd0, 1, 8'd0, 32'sd0, 1'b0, 1'b1},
        // empty B rows
        '{OP_COMPUTE, 8'd255, 8'd255, Q_MAX,  0, 8'd0, 32'sd0, 1'b0, 1'b0},
        '{OP_COMPUTE, 8'd4,   8'd0,   32'sd0, 0, 8'd0, 32'sd0, 1'b0, 1'b0}
    };

    initial
    begin
        product_entry_t e;
        rst_n          = 1'b0;
        item_ch.valid  = 1'b0;
        item_ch.op     = OP_LOAD_B;
        item_ch.row    = '0;
        item_ch.col    = '0;
        item_ch.value  = '0;
        error_count    = 0;
        sent_count     = 0;
        src_idle_pct   = 0;
        snk_stall_pct  = 0;
        hold_cycles    = 0;
        for (int m = 0; m < 2; m++)
        begin
            foreach (row_start[m][k])
                row_start[m][k] = 0;
            last_row[m] = 0;
        end
        foreach (col_pool[i])
            col_pool[i] = $urandom;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed[i])
        begin
            e = '{directed[i].exp_col, directed[i].exp_value,
                  directed[i].exp_sat, directed[i].exp_last};
            send_item(directed[i].op, directed[i].row, directed[i].col,
                      directed[i].value, directed[i].exp_count, e);
        end

        // random episodes; B rows stay well inside the row range
        for (int ep = 0; sent_count < 330 && last_row[MAT_B] < 110; ep++)
        begin
            if (ep == 10)
                hold_cycles = 400;  // long receiver hold, block backs up
            if ($urandom_range(0, 4) == 0)
                run_noise();
            else
                run_episode();
        end

        repeat (3) send_checked(OP_LOAD_B, last_row[MAT_B], $urandom, pick_value());
        send_checked(OP_COMPUTE, $urandom_range(0, last_row[MAT_B]), $urandom, $urandom);
        send_checked(OP_COMPUTE, last_row[MAT_B], $urandom, $urandom);

        item_ch.valid <= 1'b0;
        while (product_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("masked_sparse_matrix_product regression: pass");
        else
            $display("masked_sparse_matrix_product regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Output side: check each transfer, then pick ready for the next edge
    // ------------------------------------------------------------------------
    initial
    begin
        product_entry_t e;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
            begin
                if (product_q.size() == 0)
                begin
                    $error("unexpected result transfer: col %0d value %0d",
                           result_ch.out_col, result_ch.product_value);
                    error_count++;
                end
                else
                begin
                    e = product_q.pop_front();
                    if (result_ch.out_col !== e.out_col)
                    begin
                        $error("out_col: expected %0d, got %0d", e.out_col, result_ch.out_col);
                        error_count++;
                    end
                    if (result_ch.product_value !== e.product_value)
                    begin
                        $error("product_value: expected %0d, got %0d",
                               e.product_value, result_ch.product_value);
                        error_count++;
                    end
                    if (result_ch.saturated !== e.saturated)
                    begin
                        $error("saturated: expected %0b, got %0b",
                               e.saturated, result_ch.saturated);
                        error_count++;
                    end
                    if (result_ch.last !== e.last)
                    begin
                        $error("last: expected %0b, got %0b", e.last, result_ch.last);
                        error_count++;
                    end
                end
            end
            if (!rst_n)
                result_ch.ready <= 1'b0;
            else if (hold_cycles > 0)
            begin
                hold_cycles--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

endmodule
